>>> hdl/mstp_pkg.sv
// Shared package for the Prim spanning-tree block.
// Holds field widths, op codes and the controller/datapath command and status structs.
// No dependencies.
package mstp_pkg;

    localparam int NODE_BITS       = 6;
    localparam int COST_BITS       = 21;
    localparam int DEF_MAX_NODES   = 32;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_RUN    = 2'd2;
    // no operation is assigned to this code; the block drops such items
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic wr_uv;
        logic wr_vu;
        logic idx_clr;
        logic run_init;
        logic pass_step;
        logic pass_next;
        logic emit_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic is_add_ok;
        logic is_run;
        logic clr_done;
        logic start_ok;
        logic seq_done;
        logic found;
    } dp_status_t;

endpackage

>>> hdl/mstp_ctrl.sv
// Sequencer for the Prim spanning-tree block.
// Depends on mstp_pkg for the command and status structs.
module mstp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mstp_pkg::dp_status_t status,
    output mstp_pkg::ctrl_cmd_t  cmd,
    output logic                 busy
);
    import mstp_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_CLEAR  = 9'b000000100,
        S_ADD_A  = 9'b000001000,
        S_ADD_B  = 9'b000010000,
        S_INIT   = 9'b000100000,
        S_PASS   = 9'b001000000,
        S_DECIDE = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (status.is_clear)
                begin
                    state_next = S_CLEAR;
                end
                else if (status.is_add_ok)
                begin
                    state_next = S_ADD_A;
                end
                else if (status.is_run)
                begin
                    state_next = S_INIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ADD_A:
            begin
                cmd.wr_uv  = 1'b1;
                state_next = S_ADD_B;
            end
            S_ADD_B:
            begin
                cmd.wr_vu  = 1'b1;
                state_next = S_IDLE;
            end
            S_INIT:
            begin
                cmd.idx_clr  = 1'b1;
                cmd.run_init = 1'b1;
                state_next   = status.start_ok ? S_PASS : S_EMIT;
            end
            S_PASS:
            begin
                cmd.pass_step = 1'b1;
                if (status.seq_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.idx_clr = 1'b1;
                if (status.found)
                begin
                    cmd.pass_next = 1'b1;
                    state_next    = S_PASS;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (status.seq_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> hdl/mstp_dpath.sv
// Datapath for the Prim spanning-tree block: weight matrix, key and parent memories,
// tree marks, scan pipeline and result registers. Depends on mstp_pkg.
module mstp_dpath #(
    parameter int MAX_NODES   = mstp_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = mstp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mstp_pkg::ctrl_cmd_t             cmd,
    output mstp_pkg::dp_status_t            status,
    input  logic [1:0]                      op,
    input  logic [mstp_pkg::NODE_BITS-1:0]  node_u,
    input  logic [mstp_pkg::NODE_BITS-1:0]  node_v,
    input  logic [WEIGHT_BITS-1:0]          edge_weight,
    input  logic [mstp_pkg::NODE_BITS-1:0]  start_node,
    input  logic                            cfg_we,
    input  logic [mstp_pkg::NODE_BITS-1:0]  cfg_data,
    output logic                            result_valid,
    output logic [mstp_pkg::NODE_BITS-1:0]  node_id,
    output logic [mstp_pkg::NODE_BITS-1:0]  parent_id,
    output logic [WEIGHT_BITS-1:0]          link_weight,
    output logic                            reached,
    output logic [mstp_pkg::COST_BITS-1:0]  total_cost,
    output logic                            last
);
    import mstp_pkg::*;

    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int SUM_W     = ((COST_BITS > WEIGHT_BITS) ? COST_BITS : WEIGHT_BITS) + 1;
    localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

    // latched item fields
    logic [1:0]             op_reg;
    logic [NODE_BITS-1:0]   u_reg;
    logic [NODE_BITS-1:0]   v_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [NODE_BITS-1:0]   s_reg;

    logic [NODE_BITS-1:0]   node_count_reg;
    logic [ADDR_W-1:0]      sweep_reg;

    logic [WEIGHT_BITS-1:0] weight_mem [0:MEM_DEPTH-1];
    logic [WEIGHT_BITS-1:0] key_mem    [0:MAX_NODES-1];
    logic [CNT_W-1:0]       par_mem    [0:MAX_NODES-1];
    logic [WEIGHT_BITS-1:0] w_rd_reg;
    logic [WEIGHT_BITS-1:0] key_rd_reg;
    logic [CNT_W-1:0]       par_rd_reg;

    logic [MAX_NODES-1:0]   intree_reg;
    logic [MAX_NODES-1:0]   intree_next;

    logic [CNT_W-1:0]       idx_reg;
    logic                   vld_reg;
    logic                   emit_mode_reg;
    logic [IDX_W-1:0]       idx_d_reg;
    logic [IDX_W-1:0]       pick_reg;
    logic                   init_reg;
    logic                   run_ok_reg;
    logic [WEIGHT_BITS-1:0] best_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic                   found_reg;
    logic [COST_BITS-1:0]   total_reg;

    logic                   res_valid_reg;
    logic [NODE_BITS-1:0]   res_node_reg;
    logic [NODE_BITS-1:0]   res_par_reg;
    logic [WEIGHT_BITS-1:0] res_w_reg;
    logic                   res_reach_reg;
    logic [COST_BITS-1:0]   res_cost_reg;
    logic                   res_last_reg;

    logic [CNT_W-1:0]       n_act;
    logic                   u_ok;
    logic                   v_ok;
    logic                   start_ok;
    logic [IDX_W-1:0]       u_idx;
    logic [IDX_W-1:0]       v_idx;
    logic [IDX_W-1:0]       s_idx;
    logic                   wm_we;
    logic [ADDR_W-1:0]      wm_addr;
    logic [WEIGHT_BITS-1:0] wm_data;
    logic [ADDR_W-1:0]      rd_addr;
    logic [IDX_W-1:0]       rd_idx;
    logic                   issue;

    logic                   pass_act;
    logic                   emit_act;
    logic                   in_t;
    logic [WEIGHT_BITS-1:0] old_key;
    logic                   upd;
    logic [WEIGHT_BITS-1:0] new_key;
    logic                   take;
    logic                   tbl_we;
    logic [CNT_W-1:0]       par_wdata;

    logic                   e_reach;
    logic                   e_link;
    logic [WEIGHT_BITS-1:0] e_w;
    logic [CNT_W-1:0]       e_par;
    logic [SUM_W-1:0]       e_sum;
    logic [COST_BITS-1:0]   e_total;
    logic                   e_last;

    // clamp the node count register into 1..MAX_NODES
    always_comb
    begin
        priority if (node_count_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (int'(node_count_reg) > MAX_NODES)
        begin
            n_act = CNT_W'(MAX_NODES);
        end
        else
        begin
            n_act = CNT_W'(node_count_reg);
        end
    end

    assign u_ok     = (int'(u_reg) >= 1) && (int'(u_reg) <= MAX_NODES);
    assign v_ok     = (int'(v_reg) >= 1) && (int'(v_reg) <= MAX_NODES);
    assign start_ok = (int'(s_reg) >= 1) && (int'(s_reg) <= int'(n_act));
    assign u_idx    = IDX_W'(u_reg - NODE_BITS'(1));
    assign v_idx    = IDX_W'(v_reg - NODE_BITS'(1));
    assign s_idx    = IDX_W'(s_reg - NODE_BITS'(1));

    // weight matrix port: row is the scanned node, column the last node taken
    always_comb
    begin
        wm_we = cmd.clr_step | cmd.wr_uv | cmd.wr_vu;
        priority if (cmd.clr_step)
        begin
            wm_addr = sweep_reg;
            wm_data = NO_EDGE;
        end
        else if (cmd.wr_uv)
        begin
            wm_addr = {u_idx, v_idx};
            wm_data = w_reg;
        end
        else
        begin
            wm_addr = {v_idx, u_idx};
            wm_data = w_reg;
        end
    end

    assign rd_idx  = idx_reg[IDX_W-1:0];
    assign rd_addr = {rd_idx, pick_reg};
    assign issue   = (cmd.pass_step | cmd.emit_step) && (idx_reg < n_act);

    always_ff @(posedge clk)
    begin
        if (wm_we)
        begin
            weight_mem[wm_addr] <= wm_data;
        end
        w_rd_reg <= weight_mem[rd_addr];
    end

    // relax one node and track the lightest fringe key
    always_comb
    begin
        pass_act  = vld_reg && !emit_mode_reg;
        in_t      = intree_reg[idx_d_reg];
        old_key   = init_reg ? NO_EDGE : key_rd_reg;
        upd       = !in_t && (w_rd_reg < old_key);
        new_key   = upd ? w_rd_reg : old_key;
        take      = pass_act && !in_t && (new_key < best_reg);
        tbl_we    = pass_act && (init_reg || upd);
        par_wdata = upd ? (CNT_W'(pick_reg) + CNT_W'(1)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            key_mem[idx_d_reg] <= new_key;
            par_mem[idx_d_reg] <= par_wdata;
        end
        if (issue)
        begin
            key_rd_reg <= key_mem[rd_idx];
            par_rd_reg <= par_mem[rd_idx];
        end
    end

    // result of one node
    always_comb
    begin
        emit_act = vld_reg && emit_mode_reg;
        e_reach  = run_ok_reg && intree_reg[idx_d_reg];
        e_link   = e_reach && (par_rd_reg != '0);
        e_w      = e_link ? key_rd_reg : '0;
        e_par    = e_link ? par_rd_reg : '0;
        e_sum    = SUM_W'(total_reg) + SUM_W'(e_w);
        e_total  = (e_sum > SUM_W'(COST_MAX)) ? COST_MAX : COST_BITS'(e_sum);
        e_last   = (CNT_W'(idx_d_reg) + CNT_W'(1)) == n_act;
    end

    always_comb
    begin
        intree_next = intree_reg;
        priority if (cmd.run_init)
        begin
            intree_next        = '0;
            intree_next[s_idx] = start_ok;
        end
        else if (cmd.pass_next)
        begin
            intree_next[best_idx_reg] = 1'b1;
        end
        else
        begin
            intree_next = intree_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            u_reg  <= node_u;
            v_reg  <= node_v;
            w_reg  <= edge_weight;
            s_reg  <= start_node;
        end
        idx_d_reg <= rd_idx;
        if (cmd.run_init)
        begin
            pick_reg   <= s_idx;
            run_ok_reg <= start_ok;
        end
        else if (cmd.pass_next)
        begin
            pick_reg <= best_idx_reg;
        end
        if (take)
        begin
            best_idx_reg <= idx_d_reg;
        end
        if (emit_act)
        begin
            res_node_reg  <= NODE_BITS'(CNT_W'(idx_d_reg) + CNT_W'(1));
            res_par_reg   <= NODE_BITS'(e_par);
            res_w_reg     <= e_w;
            res_reach_reg <= e_reach;
            res_cost_reg  <= e_last ? e_total : '0;
            res_last_reg  <= e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_BITS'(1);
            sweep_reg      <= '0;
            intree_reg     <= '0;
            idx_reg        <= '0;
            vld_reg        <= 1'b0;
            emit_mode_reg  <= 1'b0;
            init_reg       <= 1'b0;
            best_reg       <= NO_EDGE;
            found_reg      <= 1'b0;
            total_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
            intree_reg    <= intree_next;
            vld_reg       <= issue;
            emit_mode_reg <= cmd.emit_step;
            if (cmd.run_init)
            begin
                init_reg <= 1'b1;
            end
            else if (cmd.pass_next)
            begin
                init_reg <= 1'b0;
            end
            if (cmd.idx_clr)
            begin
                idx_reg   <= '0;
                best_reg  <= NO_EDGE;
                found_reg <= 1'b0;
                total_reg <= '0;
            end
            else
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (take)
                begin
                    best_reg  <= new_key;
                    found_reg <= 1'b1;
                end
                if (emit_act)
                begin
                    total_reg <= e_total;
                end
            end
            res_valid_reg <= emit_act;
        end
    end

    always_comb
    begin
        status.is_clear  = (op_reg == OP_CLEAR);
        status.is_add_ok = (op_reg == OP_ADD) && u_ok && v_ok;
        status.is_run    = (op_reg == OP_RUN);
        status.clr_done  = &sweep_reg;
        status.start_ok  = start_ok;
        status.seq_done  = (idx_reg == n_act) && !vld_reg;
        status.found     = found_reg;
    end

    assign result_valid = res_valid_reg;
    assign node_id      = res_node_reg;
    assign parent_id    = res_par_reg;
    assign link_weight  = res_w_reg;
    assign reached      = res_reach_reg;
    assign total_cost   = res_cost_reg;
    assign last         = res_last_reg;

    a_found_has_edge: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_reg != NO_EDGE))
        else $error("fringe minimum marked found but holds no-edge");

    a_pick_in_tree: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass_step |-> intree_reg[pick_reg])
        else $error("relaxing from a node not in the tree");

endmodule

>>> hdl/minimum_spanning_tree_prim.sv
// Prim minimum spanning tree over a stored adjacency matrix: clear sweeps the one-port matrix,
// add edge makes two matrix writes, and run makes one matrix read per node per round over the
// n active nodes. Results come out one a cycle.
// One item at a time: start is taken only while busy is low. Results are strobed and cannot stall.
// Reset: asynchronous, active low; a busy sweep clears every matrix entry.
// Depends on mstp_pkg, mstp_ctrl and mstp_dpath.
module minimum_spanning_tree_prim #(
    parameter int MAX_NODES   = mstp_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = mstp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // item channel
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      op,
    input  logic [mstp_pkg::NODE_BITS-1:0]  node_u,
    input  logic [mstp_pkg::NODE_BITS-1:0]  node_v,
    input  logic [WEIGHT_BITS-1:0]          edge_weight,
    input  logic [mstp_pkg::NODE_BITS-1:0]  start_node,
    // node count register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mstp_pkg::NODE_BITS-1:0]  cfg_data,
    // result channel
    output logic                            result_valid,
    output logic [mstp_pkg::NODE_BITS-1:0]  node_id,
    output logic [mstp_pkg::NODE_BITS-1:0]  parent_id,
    output logic [WEIGHT_BITS-1:0]          link_weight,
    output logic                            reached,
    output logic [mstp_pkg::COST_BITS-1:0]  total_cost,
    output logic                            last
);
    import mstp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The write is always taken, unchecked; the user must issue it only while the block is idle.
    assign cfg_ready = 1'b1;

    // Sequencer: decode the item, then step the datapath through clear, add or run, or drop it.
    mstp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath: each run pass reads one matrix column for the last node taken,
    // relaxes the fringe keys and finds the next node in the same sweep.
    mstp_dpath #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (op),
        .node_u       (node_u),
        .node_v       (node_v),
        .edge_weight  (edge_weight),
        .start_node   (start_node),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .node_id      (node_id),
        .parent_id    (parent_id),
        .link_weight  (link_weight),
        .reached      (reached),
        .total_cost   (total_cost),
        .last         (last)
    );

    // An accepted item always occupies the block on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // Results only come out of a run in progress.
    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe outside a run");

    // The cost is reported only on the closing result.
    a_cost_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> (total_cost == '0))
        else $error("total cost on a result that is not last");

endmodule

>>> test/mstp_tb_pkg.sv
// Scoreboard for the Prim spanning-tree testbench: a software copy of the weight matrix,
// the node count and the tree growth, plus the queue of node rows still due from the block.
// Depends on mstp_pkg.
package mstp_tb_pkg;
    import mstp_pkg::*;

    localparam int NODES = DEF_MAX_NODES;
    localparam int WB = DEF_WEIGHT_BITS;
    localparam logic [WB-1:0] NO_EDGE = '1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [NODE_BITS-1:0] node_id;
        logic [NODE_BITS-1:0] parent_id;
        logic [WB-1:0]        link_weight;
        logic                 reached;
        logic [COST_BITS-1:0] total_cost;
        logic                 last;
    } tree_row_t;

    class tree_scoreboard;
        logic [WB-1:0]        edge_w [NODES][NODES];
        logic [NODE_BITS-1:0] node_count;
        tree_row_t            rows_due[$];
        int                   errors;
        int                   rows_checked;
        int                   runs;

        function new();
            wipe_matrix();
            node_count   = 1;
            errors       = 0;
            rows_checked = 0;
            runs         = 0;
        endfunction

        function void wipe_matrix();
            for (int r = 0; r < NODES; r++)
                for (int c = 0; c < NODES; c++)
                    edge_w[r][c] = NO_EDGE;
        endfunction

        function void set_node_count(logic [NODE_BITS-1:0] value);
            node_count = value;
        endfunction

        function int active_nodes();
            if (node_count == 0)
                return 1;
            if (node_count > NODES)
                return NODES;
            return node_count;
        endfunction

        // Returns 1 when the item has an effect on the block.
        function bit note_item(logic [1:0] op_code, logic [NODE_BITS-1:0] u,
                               logic [NODE_BITS-1:0] v, logic [WB-1:0] w,
                               logic [NODE_BITS-1:0] root);
            case (op_code)
                OP_CLEAR: wipe_matrix();
                OP_ADD:
                    begin
                        if (u < 1 || u > NODES || v < 1 || v > NODES)
                            return 0;
                        edge_w[u-1][v-1] = w;
                        edge_w[v-1][u-1] = w;
                    end
                OP_RUN: grow_tree(root);
                default: return 0;
            endcase
            return 1;
        endfunction

        // Grow the tree from root and queue one row per active node.
        function void grow_tree(logic [NODE_BITS-1:0] root);
            int            n;
            int            s;
            int            pick;
            int            total;
            bit            ok;
            bit            found;
            logic [WB-1:0] best;
            logic [WB-1:0] key [NODES];
            int            par [NODES];
            bit            joined [NODES];
            tree_row_t     row;

            n     = active_nodes();
            ok    = (root >= 1) && (root <= n);
            total = 0;
            for (int i = 0; i < NODES; i++)
            begin
                joined[i] = 0;
                par[i]    = 0;
                key[i]    = NO_EDGE;
            end
            if (ok)
            begin
                s = root - 1;
                joined[s] = 1;
                for (int i = 0; i < n; i++)
                begin
                    par[i] = root;
                    key[i] = edge_w[i][s];
                end
                par[s] = 0;
                for (int rnd = 1; rnd < n; rnd++)
                begin
                    best  = NO_EDGE;
                    found = 0;
                    pick  = 0;
                    for (int i = 0; i < n; i++)
                        if (!joined[i] && key[i] < best)
                        begin
                            best  = key[i];
                            pick  = i;
                            found = 1;
                        end
                    if (!found)
                        break;
                    joined[pick] = 1;
                    for (int i = 0; i < n; i++)
                        if (!joined[i] && edge_w[i][pick] < key[i])
                        begin
                            key[i] = edge_w[i][pick];
                            par[i] = pick + 1;
                        end
                end
            end
            runs++;
            for (int i = 0; i < n; i++)
            begin
                row = '0;
                row.node_id = NODE_BITS'(i + 1);
                if (ok && joined[i])
                begin
                    row.reached = 1'b1;
                    if (par[i] != 0)
                    begin
                        row.parent_id   = NODE_BITS'(par[i]);
                        row.link_weight = key[i];
                        total += key[i];
                    end
                end
                if (i == n - 1)
                begin
                    row.last       = 1'b1;
                    row.total_cost = (total > COST_MAX) ? COST_MAX : COST_BITS'(total);
                end
                rows_due.push_back(row);
            end
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        function void check_row(tree_row_t got);
            tree_row_t want;
            if (rows_due.size() == 0)
            begin
                flag($sformatf("unexpected row: node %0d parent %0d weight %0d reached %0b",
                               got.node_id, got.parent_id, got.link_weight, got.reached));
                return;
            end
            want = rows_due.pop_front();
            rows_checked++;
            if (got.node_id !== want.node_id || got.parent_id !== want.parent_id ||
                got.link_weight !== want.link_weight || got.reached !== want.reached ||
                got.total_cost !== want.total_cost || got.last !== want.last)
                flag($sformatf({"row mismatch: want node %0d parent %0d weight %0d reached %0b",
                                " cost %0d last %0b / got node %0d parent %0d weight %0d",
                                " reached %0b cost %0d last %0b"},
                               want.node_id, want.parent_id, want.link_weight, want.reached,
                               want.total_cost, want.last, got.node_id, got.parent_id,
                               got.link_weight, got.reached, got.total_cost, got.last));
        endfunction

        function int pending();
            return rows_due.size();
        endfunction
    endclass

endpackage

>>> test/testbench.sv
// Top-level testbench for minimum_spanning_tree_prim: drives clear, add and run items,
// writes the node count between phases and checks every node row against the scoreboard.
// Depends on mstp_pkg, mstp_tb_pkg and the block's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mstp_pkg::*;
    import mstp_tb_pkg::*;

    // Worst case is roughly 500 items, each a full 32-node run, plus
    // config hold-offs; allow several times that.
    localparam int CYCLE_LIMIT   = 3_000_000;
    // Longer than a full clear sweep or a 32-node run.
    localparam int SETTLE_CYCLES = 1300;
    localparam int PHASES        = 10;
    localparam int RANDOM_ITEMS  = 456;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic [1:0]           op          = OP_CLEAR;
    logic [NODE_BITS-1:0] node_u      = '0;
    logic [NODE_BITS-1:0] node_v      = '0;
    logic [WB-1:0]        edge_weight = '0;
    logic [NODE_BITS-1:0] start_node  = '0;
    logic                 cfg_valid   = 1'b0;
    logic [NODE_BITS-1:0] cfg_data    = '0;
    logic                 busy;
    logic                 cfg_ready;
    logic                 result_valid;
    logic [NODE_BITS-1:0] node_id;
    logic [NODE_BITS-1:0] parent_id;
    logic [WB-1:0]        link_weight;
    logic                 reached;
    logic [COST_BITS-1:0] total_cost;
    logic                 last;

    tree_scoreboard sb = new();
    int cycle_count = 0;
    int items_sent  = 0;
    bit idle_on     = 1'b1;

    always #6 clk = ~clk;

    minimum_spanning_tree_prim i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .node_u       (node_u),
        .node_v       (node_v),
        .edge_weight  (edge_weight),
        .start_node   (start_node),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .node_id      (node_id),
        .parent_id    (parent_id),
        .link_weight  (link_weight),
        .reached      (reached),
        .total_cost   (total_cost),
        .last         (last)
    );

    // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d rows still due", cycle_count, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sample each strobed row at the edge that ends its cycle; rows cannot be held off.
    always @(posedge clk)
    begin : row_monitor
        tree_row_t seen;
        if (rst_n && result_valid)
        begin
            seen = '{node_id: node_id, parent_id: parent_id, link_weight: link_weight,
                     reached: reached, total_cost: total_cost, last: last};
            sb.check_row(seen);
        end
    end

    // Present one item and hold it until the block takes it (start high, busy low).
    // Leave start high on return so a following item can go back to back.
    task automatic send_item(input logic [1:0] op_code, input logic [NODE_BITS-1:0] u,
                             input logic [NODE_BITS-1:0] v, input logic [WB-1:0] w,
                             input logic [NODE_BITS-1:0] root);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        op          <= op_code;
        node_u      <= u;
        node_v      <= v;
        edge_weight <= w;
        start_node  <= root;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (sb.note_item(op_code, u, v, w, root))
            items_sent++;
    endtask

    // Drop start and hold until every queued row has come out.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write the node count only with the block idle; a clear may still be sweeping,
    // so let it finish before the write.
    task automatic write_node_count(input logic [NODE_BITS-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_node_count(value);
    endtask

    // Raw node field, any of the 64 codes.
    function automatic logic [NODE_BITS-1:0] raw_node();
        return NODE_BITS'($urandom);
    endfunction

    // Node number in 1..n.
    function automatic logic [NODE_BITS-1:0] node_upto(input int n);
        return NODE_BITS'($urandom_range(1, n));
    endfunction

    // Raw weight field, no-edge code included.
    function automatic logic [WB-1:0] raw_weight();
        return WB'($urandom);
    endfunction

    // Mostly small weights so ties are common, plus the extremes and the no-edge code.
    function automatic logic [WB-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return WB'($urandom_range(0, 3));
            4:          return NO_EDGE - WB'(1);
            5:          return raw_weight();
            6:          return '0;
            default:    return WB'($urandom_range(0, NO_EDGE - 1));
        endcase
    endfunction

    // Well-formed sequence: maybe clear, add a handful of edges among the active nodes,
    // then run from a valid root. The matrix carries over, so graphs get denser over time.
    task automatic build_and_run(input int n);
        int edges;
        if ($urandom_range(0, 5) == 0)
            send_item(OP_CLEAR, raw_node(), raw_node(), raw_weight(), raw_node());
        edges = $urandom_range(0, 10);
        for (int k = 0; k < edges; k++)
            send_item(OP_ADD, node_upto(n), node_upto(n), pick_weight(), raw_node());
        send_item(OP_RUN, raw_node(), raw_node(), raw_weight(), node_upto(n));
        if ($urandom_range(0, 3) == 0)
            send_item(OP_RUN, raw_node(), raw_node(), raw_weight(), node_upto(n));
    endtask

    // Noise: any op with raw field values, which reaches bad endpoints, bad roots and op 3.
    // Keep clears rare since each one costs a full matrix sweep.
    task automatic noise_item();
        logic [1:0] code;
        code = ($urandom_range(0, 7) == 0) ? OP_CLEAR : 2'($urandom_range(1, 3));
        send_item(code, raw_node(), raw_node(), raw_weight(), raw_node());
    endtask

    // Short directed pass with four active nodes.
    task automatic directed_items();
        send_item(OP_RUN,    0,  0,  0,          1);   // run on the reset matrix
        send_item(OP_CLEAR,  63, 63, NO_EDGE,    63);
        send_item(OP_ADD,    1,  2,  0,          0);   // lightest weight
        send_item(OP_ADD,    2,  3,  NO_EDGE-1,  0);   // heaviest real weight
        send_item(OP_ADD,    3,  4,  7,          0);
        send_item(OP_ADD,    1,  4,  7,          0);   // tie: lowest index must win
        send_item(OP_ADD,    2,  4,  7,          0);
        send_item(OP_ADD,    0,  2,  5,          0);   // bad endpoints, ignored
        send_item(OP_ADD,    2,  63, 5,          0);
        send_item(OP_ADD,    33, 1,  5,          0);
        send_item(OP_ADD,    4,  4,  1,          0);   // self edge, stored but inert
        send_item(OP_ADD,    1,  32, 100,        0);   // beyond node count, still stored
        send_item(OP_UNUSED, 1,  2,  3,          1);   // unused op, ignored
        send_item(OP_RUN,    0,  0,  0,          1);
        send_item(OP_RUN,    0,  0,  0,          0);   // bad roots: everything unreached
        send_item(OP_RUN,    0,  0,  0,          5);
        send_item(OP_RUN,    0,  0,  0,          63);
        send_item(OP_ADD,    3,  2,  NO_EDGE,    0);   // no-edge weight removes the edge
        send_item(OP_RUN,    0,  0,  0,          3);
        send_item(OP_ADD,    4,  1,  3,          0);   // reversed endpoint order
        send_item(OP_RUN,    0,  0,  0,          4);
        send_item(OP_CLEAR,  0,  0,  0,          0);
        send_item(OP_RUN,    0,  0,  0,          2);
    endtask

    initial
    begin : stimulus
        logic [NODE_BITS-1:0] phase_count [PHASES];
        int n;
        int quota;

        // Include zero (acts as one) and values above the node limit.
        phase_count = '{6'd32, 6'd0, 6'd7, 6'd63, 6'd12, 6'd1, 6'd5, 6'd20, 6'd2, 6'd32};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The reset sweep runs first; write_node_count waits it out.
        write_node_count(4);
        directed_items();

        for (int p = 0; p < PHASES; p++)
        begin
            write_node_count(phase_count[p]);
            n = (phase_count[p] == 0) ? 1 : (phase_count[p] > NODES) ? NODES : phase_count[p];
            // Keep the last phase free of gaps.
            idle_on = (p != PHASES - 1);
            quota = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < quota)
            begin
                if (idle_on && $urandom_range(0, 24) == 0)
                    wait_drained();
                if ($urandom_range(0, 4) == 0)
                    noise_item();
                else
                    build_and_run(n);
            end
        end

        // Drain, then hold long enough to catch any stray row.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d effective items over node counts 0 to 63, %0d tree runs,",
                 items_sent, sb.runs);
        $display("%0d node rows checked, %0d mismatches.", sb.rows_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> minimum_spanning_tree_prim.f
hdl/mstp_pkg.sv
hdl/mstp_ctrl.sv
hdl/mstp_dpath.sv
hdl/minimum_spanning_tree_prim.sv
test/mstp_tb_pkg.sv
test/testbench.sv
